@@ src/first_fit_heap_allocator_assert.svh @@
// assertion macros for the first-fit heap allocator
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define FFHA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define FFHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define FFHA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define FFHA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ src/ffha_pkg.sv @@
// types, constants and codes shared by the heap allocator modules
package ffha_pkg;

    localparam int POOL_BYTES   = 4096;
    localparam int HEADER_BYTES = 16;
    localparam int ADDR_W       = $clog2(POOL_BYTES);
    localparam int SIZE_W       = 13;
    localparam int POS_W        = SIZE_W + 1;
    localparam int WORD_W       = SIZE_W + 1;
    localparam int STATUS_W     = 2;
    localparam int S_TDATA_W    = 32;
    localparam int M_TDATA_W    = 16;

    localparam logic [POS_W-1:0] HDR        = POS_W'(HEADER_BYTES);
    localparam logic [POS_W-1:0] POOL_LIMIT = POS_W'(POOL_BYTES);

    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [SIZE_W-1:0] size_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_EXHAUSTED = 2'd1,
        STATUS_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_SPLIT,
        ST_MERGE,
        ST_RESP
    } ctrl_state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_START,
        CMD_STEP,
        CMD_FAIL_EXH,
        CMD_FAIL_NF,
        CMD_APPEND,
        CMD_SPLIT_HEAD,
        CMD_SPLIT_REST,
        CMD_FREE_MATCH,
        CMD_FREE_MERGE,
        CMD_OUT
    } dp_cmd_t;

    typedef struct packed {
        logic is_free;
        logic exhausted;
        logic in_range;
        logic alloc_fit;
        logic free_match;
        logic out_ready;
    } dp_status_t;

endpackage

@@ src/ffha_controller.sv @@
// sequencing state machine for the heap allocator
module ffha_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  ffha_pkg::dp_status_t status,
    output ffha_pkg::dp_cmd_t    cmd
);
    import ffha_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (!status.is_free)
                begin
                    if (status.exhausted || !status.in_range)
                    begin
                        state_next = ST_RESP;
                    end
                    else if (status.alloc_fit)
                    begin
                        state_next = ST_SPLIT;
                    end
                end
                else
                begin
                    if (!status.in_range)
                    begin
                        state_next = ST_RESP;
                    end
                    else if (status.free_match)
                    begin
                        state_next = ST_MERGE;
                    end
                end
            end
            ST_SPLIT: state_next = ST_RESP;
            ST_MERGE: state_next = ST_RESP;
            ST_RESP:
            begin
                if (status.out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        cmd      = CMD_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd = CMD_START;
                end
            end
            ST_WALK:
            begin
                if (!status.is_free)
                begin
                    if (status.exhausted)
                    begin
                        cmd = CMD_FAIL_EXH;
                    end
                    else if (!status.in_range)
                    begin
                        cmd = CMD_APPEND;
                    end
                    else if (status.alloc_fit)
                    begin
                        cmd = CMD_SPLIT_HEAD;
                    end
                    else
                    begin
                        cmd = CMD_STEP;
                    end
                end
                else
                begin
                    if (!status.in_range)
                    begin
                        cmd = CMD_FAIL_NF;
                    end
                    else if (status.free_match)
                    begin
                        cmd = CMD_FREE_MATCH;
                    end
                    else
                    begin
                        cmd = CMD_STEP;
                    end
                end
            end
            ST_SPLIT: cmd = CMD_SPLIT_REST;
            ST_MERGE: cmd = CMD_FREE_MERGE;
            ST_RESP:
            begin
                if (status.out_ready)
                begin
                    cmd = CMD_OUT;
                end
            end
            default: cmd = CMD_NONE;
        endcase
    end

endmodule

@@ src/ffha_datapath.sv @@
// header store, walk registers and result register of the heap allocator
module ffha_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ffha_pkg::dp_cmd_t               cmd,
    input  logic [ffha_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tuser,
    output ffha_pkg::dp_status_t            status,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ffha_pkg::M_TDATA_W-1:0]  m_tdata
);
    import ffha_pkg::*;

    logic [WORD_W-1:0] hdr_mem [POOL_BYTES];
    logic [WORD_W-1:0] rd_data_reg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    op_t     op_reg,        op_next;
    size_t   req_reg,       req_next;
    size_t   handle_reg,    handle_next;
    pos_t    pos_reg,       pos_next;
    pos_t    prev_reg,      prev_next;
    size_t   prev_size_reg, prev_size_next;
    logic    prev_used_reg, prev_used_next;
    logic    have_prev_reg, have_prev_next;
    size_t   used_end_reg,  used_end_next;
    pos_t    tgt_reg,       tgt_next;
    pos_t    tgt_size_reg,  tgt_size_next;
    pos_t    nxt_reg,       nxt_next;
    status_t res_status_reg, res_status_next;
    size_t   res_offset_reg, res_offset_next;
    logic    m_valid_reg,   m_valid_next;
    status_t m_status_reg,  m_status_next;
    size_t   m_offset_reg,  m_offset_next;

    size_t cur_size;
    logic  cur_used;
    pos_t  step_pos;
    pos_t  split_rest;
    pos_t  used_end_ext;
    logic  merge_prev;
    logic  next_ok;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hdr_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= hdr_mem[rd_addr];
        end
    end

    assign cur_size     = rd_data_reg[SIZE_W-1:0];
    assign cur_used     = rd_data_reg[SIZE_W];
    assign used_end_ext = {1'b0, used_end_reg};
    assign step_pos     = pos_reg + HDR + {1'b0, cur_size};
    assign split_rest   = pos_reg + HDR + {1'b0, req_reg};
    assign merge_prev   = have_prev_reg && !prev_used_reg;
    assign next_ok      = (nxt_reg < used_end_ext) && ((nxt_reg + HDR) <= POOL_LIMIT)
                          && !cur_used;

    always_comb
    begin
        status.is_free    = (op_reg == OP_FREE);
        status.exhausted  = (used_end_ext + HDR + {1'b0, req_reg}) > POOL_LIMIT;
        status.in_range   = (pos_reg < used_end_ext) && (pos_reg < POOL_LIMIT);
        status.alloc_fit  = !cur_used && (cur_size >= req_reg)
                            && (({1'b0, cur_size} - {1'b0, req_reg}) > HDR);
        status.free_match = (pos_reg + HDR) == {1'b0, handle_reg};
        status.out_ready  = !m_valid_reg || m_tready;
    end

    always_comb
    begin
        op_next         = op_reg;
        req_next        = req_reg;
        handle_next     = handle_reg;
        pos_next        = pos_reg;
        prev_next       = prev_reg;
        prev_size_next  = prev_size_reg;
        prev_used_next  = prev_used_reg;
        have_prev_next  = have_prev_reg;
        used_end_next   = used_end_reg;
        tgt_next        = tgt_reg;
        tgt_size_next   = tgt_size_reg;
        nxt_next        = nxt_reg;
        res_status_next = res_status_reg;
        res_offset_next = res_offset_reg;
        m_status_next   = m_status_reg;
        m_offset_next   = m_offset_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        rd_en           = 1'b0;
        rd_addr         = '0;
        case (cmd)
            CMD_START:
            begin
                op_next        = op_t'(s_tuser);
                req_next       = s_tdata[SIZE_W-1:0];
                handle_next    = s_tdata[2*SIZE_W-1:SIZE_W];
                pos_next       = '0;
                have_prev_next = 1'b0;
                rd_en          = 1'b1;
                rd_addr        = '0;
            end
            CMD_STEP:
            begin
                prev_next      = pos_reg;
                prev_size_next = cur_size;
                prev_used_next = cur_used;
                have_prev_next = 1'b1;
                pos_next       = step_pos;
                rd_en          = 1'b1;
                rd_addr        = step_pos[ADDR_W-1:0];
            end
            CMD_FAIL_EXH:
            begin
                res_status_next = STATUS_EXHAUSTED;
                res_offset_next = '0;
            end
            CMD_FAIL_NF:
            begin
                res_status_next = STATUS_NOT_FOUND;
                res_offset_next = '0;
            end
            CMD_APPEND:
            begin
                wr_en           = used_end_ext < POOL_LIMIT;
                wr_addr         = used_end_reg[ADDR_W-1:0];
                wr_data         = {1'b1, req_reg};
                used_end_next   = SIZE_W'(used_end_ext + HDR + {1'b0, req_reg});
                res_status_next = STATUS_DONE;
                res_offset_next = SIZE_W'(used_end_ext + HDR);
            end
            CMD_SPLIT_HEAD:
            begin
                wr_en           = 1'b1;
                wr_addr         = pos_reg[ADDR_W-1:0];
                wr_data         = {1'b1, req_reg};
                res_status_next = STATUS_DONE;
                res_offset_next = SIZE_W'(pos_reg + HDR);
            end
            CMD_SPLIT_REST:
            begin
                wr_en   = split_rest < POOL_LIMIT;
                wr_addr = split_rest[ADDR_W-1:0];
                wr_data = {1'b0, SIZE_W'({1'b0, cur_size} - {1'b0, req_reg} - HDR)};
                if (step_pos > used_end_ext)
                begin
                    used_end_next = step_pos[SIZE_W-1:0];
                end
            end
            CMD_FREE_MATCH:
            begin
                wr_en    = 1'b1;
                wr_addr  = pos_reg[ADDR_W-1:0];
                wr_data  = {1'b0, cur_size};
                rd_en    = 1'b1;
                rd_addr  = step_pos[ADDR_W-1:0];
                nxt_next = step_pos;
                if (merge_prev)
                begin
                    tgt_next      = prev_reg;
                    tgt_size_next = {1'b0, prev_size_reg} + HDR + {1'b0, cur_size};
                end
                else
                begin
                    tgt_next      = pos_reg;
                    tgt_size_next = {1'b0, cur_size};
                end
                res_status_next = STATUS_DONE;
                res_offset_next = '0;
            end
            CMD_FREE_MERGE:
            begin
                wr_addr = tgt_reg[ADDR_W-1:0];
                if (next_ok)
                begin
                    wr_en   = 1'b1;
                    wr_data = {1'b0, SIZE_W'(tgt_size_reg + HDR + {1'b0, cur_size})};
                end
                else if (merge_prev)
                begin
                    wr_en   = 1'b1;
                    wr_data = {1'b0, tgt_size_reg[SIZE_W-1:0]};
                end
            end
            CMD_OUT:
            begin
                m_valid_next  = 1'b1;
                m_status_next = res_status_reg;
                m_offset_next = res_offset_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_end_reg <= '0;
            m_valid_reg  <= 1'b0;
            op_reg       <= OP_ALLOC;
        end
        else
        begin
            used_end_reg <= used_end_next;
            m_valid_reg  <= m_valid_next;
            op_reg       <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        handle_reg     <= handle_next;
        pos_reg        <= pos_next;
        prev_reg       <= prev_next;
        prev_size_reg  <= prev_size_next;
        prev_used_reg  <= prev_used_next;
        have_prev_reg  <= have_prev_next;
        tgt_reg        <= tgt_next;
        tgt_size_reg   <= tgt_size_next;
        nxt_reg        <= nxt_next;
        res_status_reg <= res_status_next;
        res_offset_reg <= res_offset_next;
        m_status_reg   <= m_status_next;
        m_offset_reg   <= m_offset_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_offset_reg, m_status_reg};

endmodule

@@ src/first_fit_heap_allocator.sv @@
// top level of the first-fit heap allocator
//
// channel  signals                     fields (lowest bit up)
// request  s_tvalid s_tready s_tdata   s_tuser: op; s_tdata: request_size, handle
// result   m_tvalid m_tready m_tdata   m_tdata: status, user_offset
//
// an item passes through the walk, an optional split or merge state and the response state
// one header is read per cycle through the single read port of the header store
// a split or a merge adds a write state; the result register frees the input side
// the next request is taken once the result is in the output register
// reset clears the used end, the op and the output valid flag; the header store needs no clearing
`include "first_fit_heap_allocator_assert.svh"

module first_fit_heap_allocator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ffha_pkg::S_TDATA_W-1:0]  s_tdata,  // request_size, handle, zero pad
    input  logic                            s_tuser,  // op
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ffha_pkg::M_TDATA_W-1:0]  m_tdata   // status, user_offset, zero pad
);
    import ffha_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    ffha_controller u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ffha_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    `FFHA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `FFHA_ASSERT_SAME(a_out_slot_free, clk, rst_n, cmd == CMD_OUT, !m_tvalid || m_tready)
    `FFHA_ASSERT_SAME(a_fail_no_offset, clk, rst_n, m_tvalid && (m_tdata[1:0] != STATUS_DONE), m_tdata[14:2] == 13'd0)

endmodule

@@ test/tb_first_fit_heap_allocator.sv @@
// self-checking testbench for the first-fit heap allocator over its request and result streams
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator;

    import ffha_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 300;
    localparam int ROOM_MARK    = 3000;

    typedef struct packed {
        status_t status;
        size_t   offset;
    } heap_reply_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    bit          idle_en     = 1'b1;
    int          fail_count  = 0;
    int          cycle_count = 0;
    int          stall_left  = 0;
    heap_reply_t head_reply;

    // shadow of the pool: one header per byte offset, plus the end of the last block
    int                hdr_len [POOL_BYTES];
    bit                hdr_busy [POOL_BYTES];
    int                heap_end = 0;

    heap_reply_t due_replies[$];
    int          live_offsets[$];
    int          freed_offsets[$];

    first_fit_heap_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_first_fit_heap_allocator NOT OK");
            $finish;
        end
    end

    // receiver stalls in bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (idle_en && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 17);
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_replies.size() == 0)
            begin
                $display("%0t: unexpected result transfer, got status %0d offset %0d",
                         $time, m_tdata[1:0], m_tdata[14:2]);
                fail_count++;
            end
            else
            begin
                head_reply = due_replies.pop_front();
                if (m_tdata[1:0] !== head_reply.status || m_tdata[14:2] !== head_reply.offset)
                begin
                    $display("%0t: expected status %0d offset %0d, got status %0d offset %0d",
                             $time, head_reply.status, head_reply.offset,
                             m_tdata[1:0], m_tdata[14:2]);
                    fail_count++;
                end
            end
        end
    end

    function automatic int first_fit(input int req);
        int pos;
        int len;
        pos = 0;
        while (pos < heap_end)
        begin
            len = hdr_len[pos];
            if (!hdr_busy[pos] && len >= req && len - req > HEADER_BYTES)
                return pos;
            pos = pos + HEADER_BYTES + len;
        end
        return -1;
    endfunction

    function automatic heap_reply_t heap_serve(input op_t op, input size_t req, input size_t hnd);
        heap_reply_t reply;
        int          pos;
        int          prev;
        int          hit;
        int          tgt;
        int          nxt;
        int          len;
        reply.status = STATUS_DONE;
        reply.offset = '0;
        if (op == OP_ALLOC)
        begin
            if (heap_end + HEADER_BYTES + int'(req) > POOL_BYTES)
            begin
                reply.status = STATUS_EXHAUSTED;
            end
            else
            begin
                pos = first_fit(int'(req));
                if (pos >= 0)
                begin
                    // split into the used part and a free remainder
                    len = hdr_len[pos];
                    hdr_len[pos]  = int'(req);
                    hdr_busy[pos] = 1'b1;
                    hdr_len[pos + HEADER_BYTES + int'(req)]  = len - int'(req) - HEADER_BYTES;
                    hdr_busy[pos + HEADER_BYTES + int'(req)] = 1'b0;
                    if (pos + HEADER_BYTES + len > heap_end)
                        heap_end = pos + HEADER_BYTES + len;
                end
                else
                begin
                    pos = heap_end;
                    hdr_len[pos]  = int'(req);
                    hdr_busy[pos] = 1'b1;
                    heap_end = pos + HEADER_BYTES + int'(req);
                end
                reply.offset = size_t'(pos + HEADER_BYTES);
            end
        end
        else
        begin
            pos  = 0;
            prev = -1;
            hit  = -1;
            while (pos < heap_end && hit < 0)
            begin
                if (pos + HEADER_BYTES == int'(hnd))
                begin
                    hit = pos;
                end
                else
                begin
                    prev = pos;
                    pos  = pos + HEADER_BYTES + hdr_len[pos];
                end
            end
            if (hit < 0)
            begin
                reply.status = STATUS_NOT_FOUND;
            end
            else
            begin
                tgt = hit;
                len = hdr_len[hit];
                hdr_busy[hit] = 1'b0;
                // the first block has nothing before it to merge with
                if (prev >= 0 && !hdr_busy[prev])
                begin
                    hdr_len[prev] = hdr_len[prev] + HEADER_BYTES + len;
                    tgt = prev;
                end
                nxt = tgt + HEADER_BYTES + hdr_len[tgt];
                if (nxt < heap_end && nxt + HEADER_BYTES <= POOL_BYTES && !hdr_busy[nxt])
                    hdr_len[tgt] = hdr_len[tgt] + HEADER_BYTES + hdr_len[nxt];
            end
        end
        return reply;
    endfunction

    task automatic send_request(input op_t op, input int req, input int hnd);
        heap_reply_t reply;
        int          hits[$];
        size_t       req_f;
        size_t       hnd_f;
        req_f = size_t'(req);
        hnd_f = size_t'(hnd);
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, hnd_f, req_f};
        do @(posedge clk); while (!s_tready);
        reply = heap_serve(op, req_f, hnd_f);
        due_replies.push_back(reply);
        if (reply.status == STATUS_DONE)
        begin
            if (op == OP_ALLOC)
            begin
                live_offsets.push_back(int'(reply.offset));
            end
            else
            begin
                hits = live_offsets.find_first_index(x) with (x == int'(hnd_f));
                if (hits.size() != 0)
                    live_offsets.delete(hits[0]);
                freed_offsets.push_back(int'(hnd_f));
                if (freed_offsets.size() > 32)
                    void'(freed_offsets.pop_front());
            end
        end
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (due_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_item();
        int  roll;
        int  req;
        bit  do_free;
        roll = $urandom_range(0, 99);
        if (roll < 4)
        begin
            // oversized request, always refused
            send_request(OP_ALLOC, 13'h1000 | $urandom_range(0, 4095), $urandom_range(0, 8191));
        end
        else if (roll < 8)
        begin
            send_request(OP_FREE, $urandom_range(0, 8191), $urandom_range(0, 8191));
        end
        else if (roll < 12 && freed_offsets.size() != 0)
        begin
            send_request(OP_FREE, $urandom_range(0, 8191),
                         freed_offsets[$urandom_range(0, freed_offsets.size() - 1)]);
        end
        else
        begin
            do_free = live_offsets.size() != 0 && roll >= 56;
            req = (roll % 4 == 0) ? $urandom_range(0, 400) : $urandom_range(0, 64);
            // keep the used end low so that holes get reused rather than appended past
            if (!do_free && heap_end + HEADER_BYTES + req > ROOM_MARK && first_fit(req) < 0)
            begin
                req = $urandom_range(0, 32);
                if (first_fit(req) < 0 && live_offsets.size() != 0)
                    do_free = 1'b1;
            end
            if (do_free)
                send_request(OP_FREE, $urandom_range(0, 8191),
                             live_offsets[$urandom_range(0, live_offsets.size() - 1)]);
            else
                send_request(OP_ALLOC, req, $urandom_range(0, 8191));
        end
    endtask

    task automatic test_directed();
        send_request(OP_ALLOC, 0, 0);
        send_request(OP_ALLOC, 8191, 0);
        send_request(OP_ALLOC, 4096, 0);
        send_request(OP_ALLOC, 32, 0);
        send_request(OP_ALLOC, 100, 0);
        send_request(OP_ALLOC, 48, 0);
        send_request(OP_FREE, 0, 32);
        // leftover equal to one header: skipped, so appended
        send_request(OP_ALLOC, 16, 0);
        send_request(OP_ALLOC, 15, 0);
        send_request(OP_FREE, 0, 80);
        send_request(OP_FREE, 0, 80);
        send_request(OP_FREE, 0, 0);
        send_request(OP_FREE, 8191, 8191);
        // first block freed, then freed again
        send_request(OP_FREE, 0, 16);
        send_request(OP_FREE, 0, 16);
        send_request(OP_FREE, 0, 32);
        send_request(OP_FREE, 0, 196);
        send_request(OP_ALLOC, 200, 0);
        // exact fit is skipped too
        send_request(OP_ALLOC, 12, 0);
        send_request(OP_FREE, 0, 260);
    endtask

    task automatic test_random(input int count);
        repeat (count) send_random_item();
    endtask

    task automatic test_drain_pause();
        repeat (4)
        begin
            repeat (10) send_random_item();
            hold_until_drained();
        end
    endtask

    task automatic test_pool_fill();
        int guard;
        // one byte past the pool, then an exact fill up to its end
        send_request(OP_ALLOC, POOL_BYTES - heap_end - HEADER_BYTES + 1, 0);
        guard = 0;
        while (heap_end + HEADER_BYTES <= POOL_BYTES && guard < 64)
        begin
            send_request(OP_ALLOC, POOL_BYTES - heap_end - HEADER_BYTES, $urandom_range(0, 8191));
            guard++;
        end
        repeat (70)
        begin
            if (live_offsets.size() != 0 && $urandom_range(0, 1) == 0)
                send_request(OP_FREE, $urandom_range(0, 8191),
                             live_offsets[$urandom_range(0, live_offsets.size() - 1)]);
            else if ($urandom_range(0, 2) == 0)
                send_request(OP_FREE, $urandom_range(0, 8191), $urandom_range(0, 8191));
            else
                send_request(OP_ALLOC, $urandom_range(0, 64), $urandom_range(0, 8191));
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(600);
        test_drain_pause();
        test_random(600);
        idle_en = 1'b0;
        test_pool_fill();
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_first_fit_heap_allocator OK");
        else
            $display("tb_first_fit_heap_allocator NOT OK");
        $finish;
    end

endmodule

@@ first_fit_heap_allocator.f @@
+incdir+src
src/ffha_pkg.sv
src/ffha_controller.sv
src/ffha_datapath.sv
src/first_fit_heap_allocator.sv
test/tb_first_fit_heap_allocator.sv
